[rtl/grbf_pkg.sv]
// shared types, constants and tables of the gaussian rbf evaluate/train block
`timescale 1ns / 1ps

package grbf_pkg;

    localparam int MAX_NEURONS = 16;
    localparam int IDX_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int CNT_W = $clog2(MAX_NEURONS + 1);
    localparam int LOOP_W = IDX_W + 1;
    localparam int ACC_W = 49 + IDX_W;
    localparam int COUNT_RESET = (16 > MAX_NEURONS) ? MAX_NEURONS : 16;
    localparam logic [23:0] RATE_RESET = 24'd6554;

    localparam logic [1:0] ACT_PREDICT = 2'd0;
    localparam logic [1:0] ACT_TRAIN = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ = 2'd3;

    localparam logic [1:0] SEL_WEIGHT = 2'd0;
    localparam logic [1:0] SEL_CENTER = 2'd1;
    localparam logic [1:0] SEL_VARIANCE = 2'd2;

    localparam logic [1:0] CFG_NEURON_COUNT = 2'd0;
    localparam logic [1:0] CFG_LEARNING_RATE = 2'd1;

    localparam logic [31:0] BAD_READ_VALUE = 32'hFFFF_0000;
    localparam logic [16:0] PHI_ONE = 17'd65536;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         table_select;
        logic [3:0]         entry_index;
        logic signed [31:0] sample_x;
        logic signed [31:0] train_factor;
        logic signed [31:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               index_error;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] x;
        logic signed [31:0] c;
        logic signed [31:0] v;
    } act_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] phi;
    } act_rsp_t;

    function automatic logic [15:0] exp_bit_factor(input logic [4:0] b);
        logic [15:0] f;
        case (b)
            5'd0:    f = 16'd65535;
            5'd1:    f = 16'd65534;
            5'd2:    f = 16'd65532;
            5'd3:    f = 16'd65528;
            5'd4:    f = 16'd65520;
            5'd5:    f = 16'd65504;
            5'd6:    f = 16'd65472;
            5'd7:    f = 16'd65408;
            5'd8:    f = 16'd65280;
            5'd9:    f = 16'd65026;
            5'd10:   f = 16'd64520;
            5'd11:   f = 16'd63520;
            5'd12:   f = 16'd61565;
            5'd13:   f = 16'd57835;
            5'd14:   f = 16'd51039;
            5'd15:   f = 16'd39750;
            5'd16:   f = 16'd24109;
            5'd17:   f = 16'd8869;
            5'd18:   f = 16'd1200;
            5'd19:   f = 16'd22;
            default: f = 16'd0;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/grbf_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module grbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/grbf_act.sv]
// gaussian activation unit: squares, serial divider and serial exp table multiply
`timescale 1ns / 1ps

module grbf_act (
    input  logic               clk,
    input  logic               rst_n,
    input  grbf_pkg::act_req_t req,
    output grbf_pkg::act_rsp_t rsp
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_SQD,
        A_SQV,
        A_SAT,
        A_DIV,
        A_EXP,
        A_DONE
    } act_state_t;

    act_state_t  state_reg;
    logic [32:0] d_reg;
    logic [31:0] v_reg;
    logic [63:0] dd_reg;
    logic [63:0] den_reg;
    logic [64:0] rem_reg;
    logic [66:0] dsh_reg;
    logic [20:0] arg_reg;
    logic [4:0]  step_reg;
    logic [16:0] p_reg;
    logic        done_reg;

    logic [32:0] ad_full;
    logic [31:0] ad;
    logic [31:0] av;
    logic [63:0] dsq;
    logic [63:0] vsq;
    logic [64:0] trial;
    logic        fit;
    logic [33:0] exp_prod;

    assign ad_full = d_reg[32] ? (~d_reg + 33'd1) : d_reg;
    assign ad = ad_full[31:0];
    assign av = v_reg[31] ? (~v_reg + 32'd1) : v_reg;
    assign dsq = ad * ad;
    assign vsq = av * av;
    assign trial = (step_reg >= 5'd4) ? {rem_reg[63:0], 1'b0} : rem_reg;
    assign fit = ({2'b00, trial} >= dsh_reg);
    assign exp_prod = p_reg * grbf_pkg::exp_bit_factor(step_reg) + 34'd32768;

    assign rsp.done = done_reg;
    assign rsp.phi = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                A_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (req.start)
                    begin
                        d_reg <= {req.x[31], req.x} - {req.c[31], req.c};
                        v_reg <= req.v;
                        if (req.v == 32'sd0)
                        begin
                            p_reg <= (req.x == req.c) ? grbf_pkg::PHI_ONE : 17'd0;
                            state_reg <= A_DONE;
                        end
                        else
                        begin
                            state_reg <= A_SQD;
                        end
                    end
                end
                A_SQD:
                begin
                    dd_reg <= dsq;
                    state_reg <= A_SQV;
                end
                A_SQV:
                begin
                    den_reg <= {vsq[62:0], 1'b0};
                    state_reg <= A_SAT;
                end
                A_SAT:
                begin
                    step_reg <= 5'd0;
                    if ({4'b0000, dd_reg} >= {den_reg, 4'b0000})
                    begin
                        arg_reg <= 21'h10_0000;
                        p_reg <= grbf_pkg::PHI_ONE;
                        state_reg <= A_EXP;
                    end
                    else
                    begin
                        rem_reg <= {1'b0, dd_reg};
                        dsh_reg <= {den_reg, 3'b000};
                        arg_reg <= 21'd0;
                        state_reg <= A_DIV;
                    end
                end
                A_DIV:
                begin
                    rem_reg <= fit ? (trial - dsh_reg[64:0]) : trial;
                    arg_reg <= {arg_reg[19:0], fit};
                    if (step_reg < 5'd3)
                    begin
                        dsh_reg <= dsh_reg >> 1;
                    end
                    if (step_reg == 5'd19)
                    begin
                        step_reg <= 5'd0;
                        p_reg <= grbf_pkg::PHI_ONE;
                        state_reg <= A_EXP;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                A_EXP:
                begin
                    if (arg_reg[step_reg])
                    begin
                        p_reg <= exp_prod[32:16];
                    end
                    if (step_reg == 5'd20)
                    begin
                        state_reg <= A_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                A_DONE:
                begin
                    done_reg <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/gaussian_rbf_evaluate_train.sv]
// top level: neuron sequencer, weight and center/variance memories, train and predict math
//
// Input channel sample_valid/sample_ready/sample_data carries one command:
// predict, train, write entry or read entry. Each command gives exactly one
// transaction on result_valid/result_ready/result_data.
// Commands are taken one at a time; sample_ready is high only while the
// sequencer is idle. Per neuron the activation unit runs a 20-step serial
// divider and a 21-step exp table multiply; a neuron whose argument
// saturates skips the divider, and one with zero variance skips both.
// The result sits in an output register; when the receiver stalls it holds
// there, and the next command is taken meanwhile but its result waits until
// the register is free. Configuration writes (cfg_write_en, cfg_index,
// cfg_data) take effect at once and must be made while idle, which the block
// itself does not enforce. Writing the neuron count clears all three tables.
// Reset clears the tables through per-row valid bits, sets the neuron count
// to 16 and the learning rate to 6554; no clearing pass is needed.
`timescale 1ns / 1ps

module gaussian_rbf_evaluate_train (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  grbf_pkg::in_item_t  sample_data,
    output logic                result_valid,
    input  logic                result_ready,
    output grbf_pkg::out_item_t result_data,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    localparam int IW = grbf_pkg::IDX_W;
    localparam int LW = grbf_pkg::LOOP_W;
    localparam int AW = grbf_pkg::ACC_W;
    localparam int CW = grbf_pkg::CNT_W;
    localparam int NMAX = grbf_pkg::MAX_NEURONS;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ISSUE,
        S_FETCH,
        S_ACT,
        S_MAC,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_T5,
        S_T6,
        S_ROUND,
        S_WR,
        S_WFETCH,
        S_RD,
        S_RFETCH,
        S_OUT
    } state_t;

    state_t              state_reg;
    grbf_pkg::in_item_t  item_reg;
    logic                err_reg;
    logic [IW-1:0]       idx_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [31:0]  w_cur_reg;
    logic [16:0]         phi_reg;
    logic [23:0]         m1_reg;
    logic [39:0]         m2_reg;
    logic [55:0]         pl_reg;
    logic [47:0]         ph_reg;
    logic [32:0]         m3_reg;
    logic [31:0]         res_reg;
    logic [CW-1:0]       count_reg;
    logic [23:0]         rate_reg;
    logic [NMAX-1:0]     w_valid_reg;
    logic [NMAX-1:0]     cv_valid_reg;
    logic                out_valid_reg;
    grbf_pkg::out_item_t out_data_reg;

    logic        w_we;
    logic [31:0] w_wdata;
    logic [31:0] w_rdata;
    logic        cv_we;
    logic [63:0] cv_wdata;
    logic [63:0] cv_rdata;
    logic [31:0] w_rd;
    logic [63:0] cv_rd;

    grbf_pkg::act_req_t act_req;
    grbf_pkg::act_rsp_t act_rsp;

    logic                 in_ok;
    logic                 last_neuron;
    logic                 count_write;
    logic [31:0]          ax;
    logic [31:0]          ah;
    logic                 neg;
    logic [40:0]          m1_prod;
    logic [55:0]          m2_prod;
    logic [71:0]          p_sum;
    logic signed [49:0]   wp;
    logic signed [AW:0]   round_t;
    logic signed [AW:0]   round_q;
    logic signed [33:0]   w_sum;
    logic [31:0]          w_new;
    logic [63:0]          cv_merge;

    grbf_ram #(
        .WIDTH (32),
        .DEPTH (NMAX)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (idx_reg),
        .wdata (w_wdata),
        .raddr (idx_reg),
        .rdata (w_rdata)
    );

    grbf_ram #(
        .WIDTH (64),
        .DEPTH (NMAX)
    ) u_cv_ram (
        .clk   (clk),
        .we    (cv_we),
        .waddr (idx_reg),
        .wdata (cv_wdata),
        .raddr (idx_reg),
        .rdata (cv_rdata)
    );

    grbf_act u_act (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (act_req),
        .rsp   (act_rsp)
    );

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result_data = out_data_reg;

    assign in_ok = (32'(sample_data.entry_index) < 32'(count_reg));
    assign last_neuron = (({1'b0, idx_reg} + LW'(1)) >= LW'(count_reg));
    assign count_write = cfg_write_en && (cfg_index == grbf_pkg::CFG_NEURON_COUNT)
                         && (cfg_data[4:0] != 5'd0);

    assign w_rd = w_valid_reg[idx_reg] ? w_rdata : 32'd0;
    assign cv_rd = cv_valid_reg[idx_reg] ? cv_rdata : 64'd0;

    assign act_req.start = (state_reg == S_FETCH);
    assign act_req.x = item_reg.sample_x;
    assign act_req.c = cv_rd[63:32];
    assign act_req.v = cv_rd[31:0];

    assign ax = item_reg.sample_x[31] ? (~item_reg.sample_x + 32'd1) : item_reg.sample_x;
    assign ah = item_reg.train_factor[31] ? (~item_reg.train_factor + 32'd1)
                                          : item_reg.train_factor;
    assign neg = item_reg.sample_x[31] ^ item_reg.train_factor[31];

    assign m1_prod = rate_reg * phi_reg + 41'd32768;
    assign m2_prod = m1_reg * ax + 56'd32768;
    assign p_sum = {16'd0, pl_reg} + {ph_reg, 24'd0};
    assign wp = w_cur_reg * $signed({1'b0, phi_reg});
    assign round_t = {acc_reg[AW-1], acc_reg} + (AW+1)'(32768);
    assign round_q = round_t >>> 16;
    assign w_sum = neg ? ({{2{w_cur_reg[31]}}, w_cur_reg} - $signed({1'b0, m3_reg}))
                       : ({{2{w_cur_reg[31]}}, w_cur_reg} + $signed({1'b0, m3_reg}));
    assign w_new = grbf_pkg::sat32(64'(w_sum));
    assign cv_merge = (item_reg.table_select == grbf_pkg::SEL_CENTER)
                      ? {item_reg.write_value, cv_rd[31:0]}
                      : {cv_rd[63:32], item_reg.write_value};

    always_comb
    begin
        w_we = 1'b0;
        w_wdata = w_new;
        cv_we = 1'b0;
        cv_wdata = cv_merge;
        case (state_reg)
            S_T6:
            begin
                w_we = 1'b1;
            end
            S_WR:
            begin
                if (item_reg.table_select == grbf_pkg::SEL_WEIGHT)
                begin
                    w_we = 1'b1;
                    w_wdata = item_reg.write_value;
                end
            end
            S_WFETCH:
            begin
                cv_we = 1'b1;
            end
            default:
            begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(grbf_pkg::COUNT_RESET);
            rate_reg <= grbf_pkg::RATE_RESET;
            w_valid_reg <= '0;
            cv_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            if (w_we && !count_write)
            begin
                w_valid_reg[idx_reg] <= 1'b1;
            end
            if (cv_we && !count_write)
            begin
                cv_valid_reg[idx_reg] <= 1'b1;
            end
            if (count_write)
            begin
                count_reg <= (32'(cfg_data[4:0]) > NMAX) ? CW'(NMAX) : CW'(cfg_data[4:0]);
                w_valid_reg <= '0;
                cv_valid_reg <= '0;
            end
            else if (cfg_write_en && cfg_index == grbf_pkg::CFG_LEARNING_RATE
                     && cfg_data != 24'd0)
            begin
                rate_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid)
                    begin
                        item_reg <= sample_data;
                        res_reg <= 32'd0;
                        acc_reg <= '0;
                        case (sample_data.action)
                            grbf_pkg::ACT_PREDICT, grbf_pkg::ACT_TRAIN:
                            begin
                                err_reg <= 1'b0;
                                idx_reg <= '0;
                                state_reg <= S_ISSUE;
                            end
                            grbf_pkg::ACT_WRITE:
                            begin
                                err_reg <= !in_ok;
                                idx_reg <= IW'(sample_data.entry_index);
                                if (in_ok && sample_data.table_select inside
                                    {grbf_pkg::SEL_WEIGHT, grbf_pkg::SEL_CENTER,
                                     grbf_pkg::SEL_VARIANCE})
                                begin
                                    state_reg <= S_WR;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            default:
                            begin
                                err_reg <= !in_ok;
                                idx_reg <= IW'(sample_data.entry_index);
                                if (!in_ok)
                                begin
                                    res_reg <= grbf_pkg::BAD_READ_VALUE;
                                    state_reg <= S_OUT;
                                end
                                else if (sample_data.table_select inside
                                         {grbf_pkg::SEL_WEIGHT, grbf_pkg::SEL_CENTER,
                                          grbf_pkg::SEL_VARIANCE})
                                begin
                                    state_reg <= S_RD;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    w_cur_reg <= w_rd;
                    state_reg <= S_ACT;
                end
                S_ACT:
                begin
                    if (act_rsp.done)
                    begin
                        phi_reg <= act_rsp.phi;
                        state_reg <= (item_reg.action == grbf_pkg::ACT_PREDICT) ? S_MAC : S_T1;
                    end
                end
                S_MAC:
                begin
                    acc_reg <= acc_reg + AW'(wp);
                    if (last_neuron)
                    begin
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                        state_reg <= S_ISSUE;
                    end
                end
                S_T1:
                begin
                    m1_reg <= m1_prod[39:16];
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    m2_reg <= m2_prod[55:16];
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    pl_reg <= m2_reg[23:0] * ah;
                    state_reg <= S_T4;
                end
                S_T4:
                begin
                    ph_reg <= m2_reg[39:24] * ah;
                    state_reg <= S_T5;
                end
                S_T5:
                begin
                    if (p_sum[71:48] != 24'd0)
                    begin
                        m3_reg <= 33'h1_0000_0000;
                    end
                    else
                    begin
                        m3_reg <= 33'(({1'b0, p_sum[47:0]} + 49'd32768) >> 16);
                    end
                    state_reg <= S_T6;
                end
                S_T6:
                begin
                    if (last_neuron)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                        state_reg <= S_ISSUE;
                    end
                end
                S_ROUND:
                begin
                    res_reg <= grbf_pkg::sat32(64'(round_q));
                    state_reg <= S_OUT;
                end
                S_WR:
                begin
                    state_reg <= (item_reg.table_select == grbf_pkg::SEL_WEIGHT) ? S_OUT
                                                                                 : S_WFETCH;
                end
                S_WFETCH:
                begin
                    state_reg <= S_OUT;
                end
                S_RD:
                begin
                    state_reg <= S_RFETCH;
                end
                S_RFETCH:
                begin
                    case (item_reg.table_select)
                        grbf_pkg::SEL_WEIGHT: res_reg <= w_rd;
                        grbf_pkg::SEL_CENTER: res_reg <= cv_rd[63:32];
                        default:              res_reg <= cv_rd[31:0];
                    endcase
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || result_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg.result_value <= res_reg;
                        out_data_reg.index_error <= err_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/grbf_checker.sv]
// port-level assertions for the gaussian rbf evaluate/train block, bound to the top level
`timescale 1ns / 1ps

module grbf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                sample_valid,
    input logic                sample_ready,
    input grbf_pkg::in_item_t  sample_data,
    input logic                result_valid,
    input logic                result_ready,
    input grbf_pkg::out_item_t result_data,
    input logic                cfg_write_en,
    input logic [1:0]          cfg_index,
    input logic [23:0]         cfg_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    // one command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("second command taken while busy");

    // a new result only appears after the sequencer was busy with a command
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!sample_ready))
        else $error("result without a command");

    // an index error carries either zero or the bad read value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.index_error |->
            (result_data.result_value == 32'sd0 ||
             result_data.result_value == grbf_pkg::BAD_READ_VALUE))
        else $error("bad index result value");

endmodule

bind gaussian_rbf_evaluate_train grbf_checker u_grbf_checker (.*);

[tb/grbf_checker.sv]
// checker for the gaussian rbf block: predicts each result from accepted commands and compares
`timescale 1ns / 1ps

module grbf_tb_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    input  logic                sample_ready,
    input  grbf_pkg::in_item_t  sample_data,
    input  logic                result_valid,
    input  logic                result_ready,
    input  grbf_pkg::out_item_t result_data,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    output int                  fail_count,
    output int                  pending_count
);

    logic signed [31:0]  weights [grbf_pkg::MAX_NEURONS];
    logic signed [31:0]  centers [grbf_pkg::MAX_NEURONS];
    logic signed [31:0]  variances [grbf_pkg::MAX_NEURONS];
    int unsigned         active_neurons;
    logic [23:0]         eta;
    grbf_pkg::out_item_t expected_results [$];

    localparam logic [15:0] EXP_FACTORS [21] = '{
        16'd65535, 16'd65534, 16'd65532, 16'd65528, 16'd65520, 16'd65504, 16'd65472,
        16'd65408, 16'd65280, 16'd65026, 16'd64520, 16'd63520, 16'd61565, 16'd57835,
        16'd51039, 16'd39750, 16'd24109, 16'd8869, 16'd1200, 16'd22, 16'd0
    };

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] gaussian(input logic signed [63:0] x,
                                             input logic signed [63:0] c,
                                             input logic signed [63:0] v);
        logic signed [63:0] d;
        logic [63:0] dd, den, q, r, arg;
        logic [63:0] p;
        d = x - c;
        p = 64'd65536;
        if (v == 0)
        begin
            return d == 0 ? 32'd65536 : 32'd0;
        end
        dd = magnitude(d) * magnitude(d);
        den = 64'd2 * magnitude(v) * magnitude(v);
        q = dd / den;
        if (q >= 64'd16)
        begin
            arg = 64'd16 << 16;
        end
        else
        begin
            r = dd % den;
            arg = q;
            for (int b = 0; b < 16; b++)
            begin
                r = r << 1;
                arg = arg << 1;
                if (r >= den)
                begin
                    r = r - den;
                    arg[0] = 1'b1;
                end
            end
        end
        for (int b = 0; b < 21; b++)
        begin
            if (arg[b])
            begin
                p = (p * EXP_FACTORS[b] + 64'd32768) >> 16;
            end
        end
        return p[31:0];
    endfunction

    function automatic grbf_pkg::out_item_t apply_command(input grbf_pkg::in_item_t it);
        grbf_pkg::out_item_t res;
        logic signed [63:0] x, h, acc, t, delta;
        logic [63:0] ax, ah, m1, m2, m3, phi;
        logic neg, ok;
        res = '0;
        x = 64'(it.sample_x);
        h = 64'(it.train_factor);
        if (it.action == grbf_pkg::ACT_PREDICT)
        begin
            acc = 0;
            for (int i = 0; i < active_neurons; i++)
            begin
                phi = 64'(gaussian(x, 64'(centers[i]), 64'(variances[i])));
                acc += 64'(weights[i]) * $signed(phi);
            end
            t = acc + 64'sd32768;
            res.result_value = clamp32(t >>> 16);
        end
        else if (it.action == grbf_pkg::ACT_TRAIN)
        begin
            ax = magnitude(x);
            ah = magnitude(h);
            neg = (x < 0) != (h < 0);
            for (int i = 0; i < active_neurons; i++)
            begin
                phi = 64'(gaussian(x, 64'(centers[i]), 64'(variances[i])));
                m1 = (64'(eta) * phi + 64'd32768) >> 16;
                m2 = (m1 * ax + 64'd32768) >> 16;
                if (ah != 0 && m2 > ((64'd1 << 48) - 64'd1) / ah)
                begin
                    m3 = 64'd1 << 32;
                end
                else
                begin
                    m3 = (m2 * ah + 64'd32768) >> 16;
                end
                delta = neg ? -$signed(m3) : $signed(m3);
                weights[i] = clamp32(64'(weights[i]) + delta);
            end
        end
        else
        begin
            ok = 32'(it.entry_index) < active_neurons;
            res.index_error = !ok;
            if (it.action == grbf_pkg::ACT_WRITE)
            begin
                if (ok)
                begin
                    case (it.table_select)
                        grbf_pkg::SEL_WEIGHT:   weights[it.entry_index] = it.write_value;
                        grbf_pkg::SEL_CENTER:   centers[it.entry_index] = it.write_value;
                        grbf_pkg::SEL_VARIANCE: variances[it.entry_index] = it.write_value;
                        default: ;
                    endcase
                end
            end
            else if (!ok)
            begin
                res.result_value = grbf_pkg::BAD_READ_VALUE;
            end
            else
            begin
                case (it.table_select)
                    grbf_pkg::SEL_WEIGHT:   res.result_value = weights[it.entry_index];
                    grbf_pkg::SEL_CENTER:   res.result_value = centers[it.entry_index];
                    grbf_pkg::SEL_VARIANCE: res.result_value = variances[it.entry_index];
                    default:                res.result_value = '0;
                endcase
            end
        end
        return res;
    endfunction

    task automatic clear_tables();
        for (int i = 0; i < grbf_pkg::MAX_NEURONS; i++)
        begin
            weights[i] = '0;
            centers[i] = '0;
            variances[i] = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grbf_pkg::out_item_t exp_item;
        if (!rst_n)
        begin
            clear_tables();
            active_neurons = grbf_pkg::COUNT_RESET;
            eta = grbf_pkg::RATE_RESET;
            expected_results.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == grbf_pkg::CFG_NEURON_COUNT && cfg_data[4:0] != 5'd0)
                begin
                    clear_tables();
                    active_neurons = (32'(cfg_data[4:0]) > grbf_pkg::MAX_NEURONS)
                                     ? grbf_pkg::MAX_NEURONS : 32'(cfg_data[4:0]);
                end
                else if (cfg_index == grbf_pkg::CFG_LEARNING_RATE && cfg_data != 24'd0)
                begin
                    eta = cfg_data;
                end
            end
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected result transaction: %h", result_data);
                    end
                end
                else
                begin
                    exp_item = expected_results.pop_front();
                    if (exp_item.result_value !== result_data.result_value ||
                        exp_item.index_error !== result_data.index_error)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch: expected value %h err %b, got value %h err %b",
                                     exp_item.result_value, exp_item.index_error,
                                     result_data.result_value, result_data.index_error);
                        end
                    end
                end
            end
            if (sample_valid && sample_ready)
            begin
                expected_results.push_back(apply_command(sample_data));
            end
            pending_count = expected_results.size();
        end
    end

endmodule

[tb/tb_gaussian_rbf_evaluate_train.sv]
// testbench top: stimulus, configuration phases, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_gaussian_rbf_evaluate_train;

    logic                clk;
    logic                rst_n;
    logic                sample_valid;
    logic                sample_ready;
    grbf_pkg::in_item_t  sample_data;
    logic                result_valid;
    logic                result_ready;
    grbf_pkg::out_item_t result_data;
    logic                cfg_write_en;
    logic [1:0]          cfg_index;
    logic [23:0]         cfg_data;
    int                  fail_count;
    int                  pending_count;
    int                  hold_off_cycles;
    logic                quiet_receiver;

    gaussian_rbf_evaluate_train DUT (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample_data(sample_data),
        .result_valid(result_valid), .result_ready(result_ready), .result_data(result_data),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    grbf_tb_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample_data(sample_data),
        .result_valid(result_valid), .result_ready(result_ready), .result_data(result_data),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int mode;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                result_ready <= 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                mode = $urandom_range(0, 99);
                if (quiet_receiver || mode < 60)
                begin
                    result_ready <= 1'b1;
                end
                else
                begin
                    result_ready <= ($urandom_range(0, 3) == 0);
                end
            end
        end
    end

    task automatic send_command(input grbf_pkg::in_item_t it);
        sample_data <= it;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        @(negedge clk);
    endtask

    task automatic write_config(input logic [1:0] idx, input logic [23:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3, 4: return $signed(32'($urandom_range(0, 1 << 19))) - (1 <<< 18);
            5, 6: return $signed(32'($urandom_range(0, 1 << 22))) - (1 <<< 21);
            default: return $signed(32'($urandom));
        endcase
    endfunction

    function automatic grbf_pkg::in_item_t make_command(input logic [1:0] act);
        grbf_pkg::in_item_t it;
        it.action = act;
        it.table_select = 2'($urandom_range(0, 3));
        it.entry_index = 4'($urandom_range(0, 15));
        it.sample_x = pick_value();
        it.train_factor = ($urandom_range(0, 3) == 0) ? pick_value()
                                                       : $signed(32'($urandom_range(0, 1 << 18)))
                                                         - (1 <<< 17);
        it.write_value = pick_value();
        if (act == grbf_pkg::ACT_WRITE && it.table_select == grbf_pkg::SEL_VARIANCE
            && $urandom_range(0, 2) != 0)
        begin
            it.write_value = $signed(32'($urandom_range(1 << 14, 1 << 19)));
        end
        return it;
    endfunction

    task automatic send_burst_phase(input int count);
        int burst;
        int sent;
        int r;
        logic [1:0] act;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                r = $urandom_range(0, 99);
                act = (r < 40) ? grbf_pkg::ACT_WRITE
                    : (r < 60) ? grbf_pkg::ACT_READ
                    : (r < 82) ? grbf_pkg::ACT_PREDICT : grbf_pkg::ACT_TRAIN;
                send_command(make_command(act));
                sent++;
            end
            sample_valid <= 1'b0;
            if ($urandom_range(0, 2) != 0)
            begin
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
        sample_valid <= 1'b0;
    endtask

    initial
    begin
        grbf_pkg::in_item_t it;
        logic [4:0] counts [5] = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd5};
        logic [23:0] rates [5] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd65536, 24'd6554};
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample_data = '0;
        cfg_write_en = 1'b0;
        cfg_index = grbf_pkg::CFG_NEURON_COUNT;
        cfg_data = '0;
        hold_off_cycles = 0;
        quiet_receiver = 1'b1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, every action and table, bad index, zero variance
        for (int i = 0; i < 4; i++)
        begin
            it = '0;
            it.action = grbf_pkg::ACT_WRITE;
            it.table_select = 2'(i);
            it.entry_index = 4'd15;
            it.write_value = (i == 0) ? 32'sh7FFF_FFFF : (i == 1) ? 32'sh8000_0000 : 32'sd65536;
            send_command(it);
            it.action = grbf_pkg::ACT_READ;
            send_command(it);
        end
        sample_valid <= 1'b0;
        wait_drained();
        write_config(grbf_pkg::CFG_NEURON_COUNT, 24'd3);
        it = '0;
        it.action = grbf_pkg::ACT_READ;
        it.entry_index = 4'd15;
        send_command(it);
        it.action = grbf_pkg::ACT_WRITE;
        it.entry_index = 4'd0;
        it.write_value = 32'sh0001_0000;
        send_command(it);
        it.entry_index = 4'd1;
        it.table_select = grbf_pkg::SEL_VARIANCE;
        send_command(it);
        it.action = grbf_pkg::ACT_PREDICT;
        it.sample_x = 32'sh0;
        send_command(it);
        it.sample_x = 32'sh7FFF_FFFF;
        send_command(it);
        it.action = grbf_pkg::ACT_TRAIN;
        it.train_factor = 32'sh7FFF_FFFF;
        send_command(it);
        it.sample_x = 32'sh8000_0000;
        send_command(it);
        it.train_factor = 32'sh8000_0000;
        send_command(it);
        it.action = grbf_pkg::ACT_PREDICT;
        send_command(it);
        sample_valid <= 1'b0;
        quiet_receiver = 1'b0;

        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            write_config(grbf_pkg::CFG_NEURON_COUNT, 24'(counts[phase]));
            write_config(grbf_pkg::CFG_LEARNING_RATE, rates[phase]);
            if (phase == 2)
            begin
                hold_off_cycles = 2000;
            end
            send_burst_phase(phase == 1 ? 80 : 140);
        end

        wait_drained();
        repeat (50) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[gaussian_rbf_evaluate_train.f]
rtl/grbf_pkg.sv
rtl/grbf_ram.sv
rtl/grbf_act.sv
rtl/gaussian_rbf_evaluate_train.sv
rtl/grbf_checker.sv
tb/grbf_checker.sv
tb/tb_gaussian_rbf_evaluate_train.sv
